// ===== rtl/core/two_way_lru_writeback_cache_tags_defines.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the two-way LRU cache tag controller
// Clocked on aclk and disabled while aresetn is low.
// ----------------------------------------------------------------------------
`ifndef TWO_WAY_LRU_WRITEBACK_CACHE_TAGS_DEFINES_SVH
`define TWO_WAY_LRU_WRITEBACK_CACHE_TAGS_DEFINES_SVH

// Same-cycle implication
`define TLRU_ASSERT_IMP(name, ante, cons) \
    name: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("tlru: same-cycle check failed");

// Next-cycle implication
`define TLRU_ASSERT_NXT(name, ante, cons) \
    name: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("tlru: next-cycle check failed");

`endif

// ===== rtl/core/tlru_pkg.sv =====
// ----------------------------------------------------------------------------
// tlru_pkg
// Geometry, register codes, row layout and controller states of the cache tags.
// ----------------------------------------------------------------------------
`default_nettype none

package tlru_pkg;

    function automatic int floor_log2(input int v);
        int n;
        int x;
        n = 0;
        x = v;
        while (x > 1) begin
            x = x >> 1;
            n = n + 1;
        end
        return n;
    endfunction

    // geometry
    localparam int SET_COUNT  = 64;
    localparam int LINE_BYTES = 16;
    localparam int ADDR_WIDTH = 20;
    localparam int SET_BITS   = floor_log2(SET_COUNT);
    localparam int OFF_BITS   = floor_log2(LINE_BYTES);
    localparam int SET_ROWS   = 1 << SET_BITS;
    localparam int TAG_W      = ADDR_WIDTH - OFF_BITS - SET_BITS;

    // field widths
    localparam int FUNC_W     = 2;
    localparam int LINE_W     = 16;
    localparam int CYC_W      = 18;
    localparam int FLUSH_W    = 8;
    localparam int CNT_W      = 32;
    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 10;
    localparam int MW_W       = 10;
    localparam int LT_W       = 8;
    localparam int CHK_W      = 6;
    localparam int XFER_W     = 11;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_MEM_WAIT   = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_LINE_XFER  = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] CFG_HIT_CHECK  = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] CFG_MISS_CHECK = CFG_IDX_W'(3);

    // register reset values
    localparam logic [MW_W-1:0]  MEM_WAIT_RST   = MW_W'(100);
    localparam logic [LT_W-1:0]  LINE_XFER_RST  = LT_W'(8);
    localparam logic [CHK_W-1:0] HIT_CHECK_RST  = CHK_W'(6);
    localparam logic [CHK_W-1:0] MISS_CHECK_RST = CHK_W'(4);

    // fixed costs
    localparam logic [CYC_W-1:0] ADDR_RX_CYCLES  = CYC_W'(2);
    localparam logic [CYC_W-1:0] RESPONSE_CYCLES = CYC_W'(1);

    // function codes
    localparam logic [FUNC_W-1:0] FUNC_READ_BYTE = FUNC_W'(0);
    localparam logic [FUNC_W-1:0] FUNC_READ_HALF = FUNC_W'(1);
    localparam logic [FUNC_W-1:0] FUNC_WRITE     = FUNC_W'(2);
    localparam logic [FUNC_W-1:0] FUNC_FLUSH     = FUNC_W'(3);

    // one set: both ways side by side
    typedef struct packed {
        logic [1:0][TAG_W-1:0] tag;
        logic [1:0]            valid;
        logic [1:0]            dirty;
        logic [1:0]            age;
    } row_t;

    localparam int ROW_W = $bits(row_t);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOOKUP,
        ST_FL_RD,
        ST_FL_WR,
        ST_FL_DONE
    } state_t;

endpackage

`default_nettype wire

// ===== rtl/core/tlru_ram.sv =====
// ----------------------------------------------------------------------------
// tlru_ram
// Simple dual-port RAM, one write and one read port, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module tlru_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW   = $clog2(DEPTH)
) (
    input  wire logic             aclk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic             re,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// ===== rtl/core/two_way_lru_writeback_cache_tags.sv =====
// ----------------------------------------------------------------------------
// two_way_lru_writeback_cache_tags
// Tag controller of a two-way set-associative, write-back, write-allocate
// cache: tags, valid, dirty and LRU age bits, hit/miss counters, cost model.
// ----------------------------------------------------------------------------
// An access reads the set row (both ways) from the tag RAM on the accept
// beat; the lookup state then updates the row, writes it back and loads the
// result register once it is free. A flush starts with the accept beat, then
// each row is read and written back with its dirty lines dropped, and a
// final state loads the result. The tag RAM has one read and one write
// port. A new beat is taken while an earlier result is still waiting in the
// output register; the lookup then holds until that register is free. No
// clearing pass follows reset: a flip-flop per set marks rows that have been
// written, and an unmarked row reads as invalid, clean and oldest in both
// ways. Configuration beats are always accepted.
// ----------------------------------------------------------------------------
`default_nettype none
`include "two_way_lru_writeback_cache_tags_defines.svh"

module two_way_lru_writeback_cache_tags (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    // configuration writes
    input  wire logic                            cfg_valid,
    output logic                                 cfg_ready,
    input  wire logic [tlru_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [tlru_pkg::CFG_DATA_W-1:0] cfg_data,
    // access beats
    input  wire logic                            s_valid,
    output logic                                 s_ready,
    input  wire logic [tlru_pkg::FUNC_W-1:0]     s_func,
    input  wire logic [tlru_pkg::ADDR_WIDTH-1:0] s_address,
    // result beats
    output logic                                 m_valid,
    input  wire logic                            m_ready,
    output logic                                 m_hit,
    output logic                                 m_way_used,
    output logic                                 m_wrote_back,
    output logic [tlru_pkg::LINE_W-1:0]          m_victim_line,
    output logic                                 m_filled,
    output logic [tlru_pkg::CYC_W-1:0]           m_access_cycles,
    output logic [tlru_pkg::FLUSH_W-1:0]         m_flushed_lines,
    output logic [tlru_pkg::CNT_W-1:0]           m_hit_total,
    output logic [tlru_pkg::CNT_W-1:0]           m_miss_total
);

    localparam int SET_BITS = tlru_pkg::SET_BITS;
    localparam int OFF_BITS = tlru_pkg::OFF_BITS;
    localparam int TAG_W    = tlru_pkg::TAG_W;
    localparam int CYC_W    = tlru_pkg::CYC_W;
    localparam int FLUSH_W  = tlru_pkg::FLUSH_W;
    localparam int CNT_W    = tlru_pkg::CNT_W;

    // ---------------------------------------------------------------- state
    tlru_pkg::state_t state_reg, state_next;

    logic [tlru_pkg::MW_W-1:0]  mem_wait_reg;
    logic [tlru_pkg::LT_W-1:0]  line_xfer_reg;
    logic [tlru_pkg::CHK_W-1:0] hit_check_reg;
    logic [tlru_pkg::CHK_W-1:0] miss_check_reg;

    logic [tlru_pkg::SET_ROWS-1:0] row_init_reg;   // row written since reset
    logic [CNT_W-1:0]              hit_count_reg;
    logic [CNT_W-1:0]              miss_count_reg;
    logic [SET_BITS-1:0]           flush_idx_reg;

    // held item
    logic [tlru_pkg::FUNC_W-1:0] func_reg;
    logic [SET_BITS-1:0]         set_reg;
    logic [TAG_W-1:0]            tag_reg;
    logic [CYC_W-1:0]            fl_cycles_reg;
    logic [FLUSH_W-1:0]          fl_count_reg;

    // result register
    logic                        m_valid_reg;
    logic                        m_hit_reg;
    logic                        m_way_reg;
    logic                        m_wrote_reg;
    logic [tlru_pkg::LINE_W-1:0] m_victim_reg;
    logic                        m_filled_reg;
    logic [CYC_W-1:0]            m_cycles_reg;
    logic [FLUSH_W-1:0]          m_flushed_reg;
    logic [CNT_W-1:0]            m_hit_total_reg;
    logic [CNT_W-1:0]            m_miss_total_reg;

    // ---------------------------------------------------------------- tag RAM
    logic                          ram_we;
    logic [SET_BITS-1:0]           ram_waddr;
    logic [tlru_pkg::ROW_W-1:0]    ram_wdata;
    logic                          ram_re;
    logic [SET_BITS-1:0]           ram_raddr;
    logic [tlru_pkg::ROW_W-1:0]    ram_rdata;

    tlru_ram #(
        .WIDTH (tlru_pkg::ROW_W),
        .DEPTH (tlru_pkg::SET_ROWS)
    ) u_tag_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // ---------------------------------------------------------------- row view
    // The row being worked on is set_reg in a lookup and flush_idx_reg in a
    // flush. An unwritten row shows its reset contents; its tags are unseen.
    logic [SET_BITS-1:0] row_idx;
    tlru_pkg::row_t      ram_row;
    tlru_pkg::row_t      cur_row;

    assign row_idx = (state_reg == tlru_pkg::ST_LOOKUP) ? set_reg : flush_idx_reg;
    assign ram_row = tlru_pkg::row_t'(ram_rdata);

    always_comb begin
        cur_row = ram_row;
        if (!row_init_reg[row_idx]) begin
            cur_row.valid = 2'b00;
            cur_row.dirty = 2'b00;
            cur_row.age   = 2'b11;
        end
    end

    // one line transfer: request beat, memory wait, bus burst
    logic [tlru_pkg::XFER_W-1:0] xfer_cycles;
    assign xfer_cycles = tlru_pkg::XFER_W'(1) + tlru_pkg::XFER_W'(mem_wait_reg)
                       + tlru_pkg::XFER_W'(line_xfer_reg);

    // ---------------------------------------------------------------- lookup
    logic           hit0, hit1, look_hit, look_way, look_wrote;
    tlru_pkg::row_t look_row;
    logic [CYC_W-1:0] look_cycles;

    always_comb begin
        look_row   = cur_row;
        hit0       = cur_row.valid[0] && (cur_row.tag[0] == tag_reg);
        hit1       = cur_row.valid[1] && (cur_row.tag[1] == tag_reg);
        look_hit   = hit0 || hit1;
        look_way   = 1'b0;
        look_wrote = 1'b0;
        if (look_hit) begin
            look_way = !hit0;
            // ages only move when the other line is present
            if (cur_row.valid[~look_way]) begin
                look_row.age[look_way]  = 1'b0;
                look_row.age[~look_way] = 1'b1;
            end
        end else begin
            // victim: an invalid way first, else the older one, way 1 on a tie
            if (cur_row.valid[0] && cur_row.valid[1]) begin
                look_way = !(cur_row.age[0] && !cur_row.age[1]);
            end else begin
                look_way = cur_row.valid[0];
            end
            look_wrote = cur_row.valid[look_way] && cur_row.dirty[look_way];
            look_row.age             = 2'b11;
            look_row.age[look_way]   = 1'b0;
            look_row.tag[look_way]   = tag_reg;
            look_row.valid[look_way] = 1'b1;
            look_row.dirty[look_way] = 1'b0;
        end
        if (func_reg == tlru_pkg::FUNC_WRITE) begin
            look_row.dirty[look_way] = 1'b1;
        end
    end

    always_comb begin
        look_cycles = tlru_pkg::ADDR_RX_CYCLES + tlru_pkg::RESPONSE_CYCLES;
        if (look_hit) begin
            look_cycles = look_cycles + CYC_W'(hit_check_reg);
        end else begin
            look_cycles = look_cycles + CYC_W'(miss_check_reg) + CYC_W'(xfer_cycles);
            if (look_wrote) begin
                look_cycles = look_cycles + CYC_W'(xfer_cycles);
            end
        end
    end

    // ---------------------------------------------------------------- flush row
    tlru_pkg::row_t   fl_row;
    logic [1:0]       fl_drop;
    logic [CYC_W-1:0] fl_cost;

    always_comb begin
        fl_row  = cur_row;
        fl_drop = cur_row.valid & cur_row.dirty;
        for (int w = 0; w < 2; w++) begin
            if (fl_drop[w]) begin
                fl_row.valid[w] = 1'b0;
                fl_row.dirty[w] = 1'b0;
                fl_row.age[w]   = 1'b1;
            end
        end
        case (fl_drop)
            2'b11:        fl_cost = CYC_W'(xfer_cycles) << 1;
            2'b01, 2'b10: fl_cost = CYC_W'(xfer_cycles);
            default:      fl_cost = '0;
        endcase
    end

    // ---------------------------------------------------------------- control
    logic out_free;
    logic load_look;
    logic load_flush;
    logic s_accept;
    logic fl_last;

    assign out_free = !m_valid_reg || m_ready;
    assign s_accept = s_valid && s_ready;
    assign fl_last  = (flush_idx_reg == SET_BITS'(tlru_pkg::SET_ROWS - 1));

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            tlru_pkg::ST_IDLE: begin
                if (s_valid) begin
                    state_next = (s_func == tlru_pkg::FUNC_FLUSH) ? tlru_pkg::ST_FL_RD
                                                                  : tlru_pkg::ST_LOOKUP;
                end
            end
            tlru_pkg::ST_LOOKUP: begin
                if (out_free) begin
                    state_next = tlru_pkg::ST_IDLE;
                end
            end
            tlru_pkg::ST_FL_RD: begin
                state_next = tlru_pkg::ST_FL_WR;
            end
            tlru_pkg::ST_FL_WR: begin
                state_next = fl_last ? tlru_pkg::ST_FL_DONE : tlru_pkg::ST_FL_RD;
            end
            tlru_pkg::ST_FL_DONE: begin
                if (out_free) begin
                    state_next = tlru_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = tlru_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb begin
        s_ready    = 1'b0;
        ram_re     = 1'b0;
        ram_raddr  = s_address[OFF_BITS +: SET_BITS];
        ram_we     = 1'b0;
        ram_waddr  = set_reg;
        ram_wdata  = look_row;
        load_look  = 1'b0;
        load_flush = 1'b0;
        case (state_reg)
            tlru_pkg::ST_IDLE: begin
                s_ready = 1'b1;
                ram_re  = s_valid;
            end
            tlru_pkg::ST_LOOKUP: begin
                ram_we    = out_free;
                load_look = out_free;
            end
            tlru_pkg::ST_FL_RD: begin
                ram_re    = 1'b1;
                ram_raddr = flush_idx_reg;
            end
            tlru_pkg::ST_FL_WR: begin
                ram_we    = 1'b1;
                ram_waddr = flush_idx_reg;
                ram_wdata = fl_row;
            end
            tlru_pkg::ST_FL_DONE: begin
                load_flush = out_free;
            end
            default: begin
                s_ready = 1'b0;
            end
        endcase
    end

    assign cfg_ready = 1'b1;

    // ---------------------------------------------------------------- registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= tlru_pkg::ST_IDLE;
            m_valid_reg    <= 1'b0;
            row_init_reg   <= '0;
            hit_count_reg  <= '0;
            miss_count_reg <= '0;
            flush_idx_reg  <= '0;
            mem_wait_reg   <= tlru_pkg::MEM_WAIT_RST;
            line_xfer_reg  <= tlru_pkg::LINE_XFER_RST;
            hit_check_reg  <= tlru_pkg::HIT_CHECK_RST;
            miss_check_reg <= tlru_pkg::MISS_CHECK_RST;
        end else begin
            state_reg <= state_next;

            if (load_look || load_flush) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end

            if (load_look) begin
                row_init_reg[set_reg] <= 1'b1;
                if (look_hit) begin
                    hit_count_reg <= hit_count_reg + CNT_W'(1);
                end else begin
                    miss_count_reg <= miss_count_reg + CNT_W'(1);
                end
            end

            if (state_reg == tlru_pkg::ST_FL_WR) begin
                row_init_reg[flush_idx_reg] <= 1'b1;
                flush_idx_reg               <= flush_idx_reg + SET_BITS'(1);
            end

            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    tlru_pkg::CFG_MEM_WAIT:   mem_wait_reg   <= cfg_data[tlru_pkg::MW_W-1:0];
                    tlru_pkg::CFG_LINE_XFER:  line_xfer_reg  <= cfg_data[tlru_pkg::LT_W-1:0];
                    tlru_pkg::CFG_HIT_CHECK:  hit_check_reg  <= cfg_data[tlru_pkg::CHK_W-1:0];
                    tlru_pkg::CFG_MISS_CHECK: miss_check_reg <= cfg_data[tlru_pkg::CHK_W-1:0];
                    default: begin
                    end
                endcase
            end
        end
    end

    // payload, no reset
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            func_reg      <= s_func;
            set_reg       <= s_address[OFF_BITS +: SET_BITS];
            tag_reg       <= s_address[OFF_BITS + SET_BITS +: TAG_W];
            fl_cycles_reg <= '0;
            fl_count_reg  <= '0;
        end

        if (state_reg == tlru_pkg::ST_FL_WR) begin
            fl_cycles_reg <= fl_cycles_reg + fl_cost;
            fl_count_reg  <= fl_count_reg + FLUSH_W'(fl_drop[0]) + FLUSH_W'(fl_drop[1]);
        end

        if (load_look) begin
            m_hit_reg     <= look_hit;
            m_way_reg     <= look_way;
            m_wrote_reg   <= look_wrote;
            m_victim_reg  <= look_wrote
                           ? tlru_pkg::LINE_W'({cur_row.tag[look_way], set_reg}) : '0;
            m_filled_reg  <= !look_hit;
            m_cycles_reg  <= look_cycles;
            m_flushed_reg <= '0;
            m_hit_total_reg  <= look_hit ? hit_count_reg + CNT_W'(1) : hit_count_reg;
            m_miss_total_reg <= look_hit ? miss_count_reg : miss_count_reg + CNT_W'(1);
        end else if (load_flush) begin
            m_hit_reg        <= 1'b0;
            m_way_reg        <= 1'b0;
            m_wrote_reg      <= 1'b0;
            m_victim_reg     <= '0;
            m_filled_reg     <= 1'b0;
            m_cycles_reg     <= fl_cycles_reg;
            m_flushed_reg    <= fl_count_reg;
            m_hit_total_reg  <= hit_count_reg;
            m_miss_total_reg <= miss_count_reg;
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_hit           = m_hit_reg;
    assign m_way_used      = m_way_reg;
    assign m_wrote_back    = m_wrote_reg;
    assign m_victim_line   = m_victim_reg;
    assign m_filled        = m_filled_reg;
    assign m_access_cycles = m_cycles_reg;
    assign m_flushed_lines = m_flushed_reg;
    assign m_hit_total     = m_hit_total_reg;
    assign m_miss_total    = m_miss_total_reg;

    // ---------------------------------------------------------------- checks
    logic st_lookup;
    logic st_fl_rd;
    logic st_fl_wr;

    assign st_lookup = (state_reg == tlru_pkg::ST_LOOKUP);
    assign st_fl_rd  = (state_reg == tlru_pkg::ST_FL_RD);
    assign st_fl_wr  = (state_reg == tlru_pkg::ST_FL_WR);

    // tag RAM is only written by a lookup or a flush write-back step
    `TLRU_ASSERT_IMP(a_ram_we_state, ram_we, st_lookup || st_fl_wr)
    // an accepted beat always starts a lookup or a flush walk
    `TLRU_ASSERT_NXT(a_accept_starts, s_accept, st_lookup || st_fl_rd)
    // a fill only ever follows a miss
    `TLRU_ASSERT_IMP(a_fill_on_miss, m_valid_reg && m_filled_reg, !m_hit_reg)
    // a write-back only happens on the way to a fill
    `TLRU_ASSERT_IMP(a_wb_with_fill, m_valid_reg && m_wrote_reg, m_filled_reg)
    // a flush cannot drop more lines than the cache holds
    `TLRU_ASSERT_IMP(a_flush_bound, m_valid_reg, m_flushed_reg <= FLUSH_W'(2 * tlru_pkg::SET_ROWS))

endmodule

`default_nettype wire
